>>> design/hgcd_pkg.sv
// Shared types, constants and fixed-point helpers for the great-circle distance pipeline.
`timescale 1ns / 1ps

package hgcd_pkg;

    // Datapath word for CORDIC x, y and z values (Q30, signed).
    localparam int CW = 34;
    typedef logic signed [CW-1:0] cw_t;

    // Wide angle word used before range reduction (Q30, signed).
    localparam int AW = 36;
    typedef logic signed [AW-1:0] ang_t;

    // Integer square root: one result bit per step over a 62-bit radicand.
    localparam int SQRT_STEPS = 31;
    localparam int SQW = 62;
    typedef logic [SQW-1:0] sq_t;

    // Microdegree input words after differencing.
    localparam int DW = 30;
    typedef logic signed [DW-1:0] udeg_t;

    localparam int RADIUS_W = 24;
    localparam int DIST_W = 36;
    localparam int HAV_W = 31;

    localparam cw_t ONE_Q30 = 34'sd1073741824;
    localparam cw_t GAIN_INV_Q30 = 34'sd652032874;
    localparam ang_t PI_Q30 = 36'sd3373259426;
    localparam ang_t HALF_PI_Q30 = 36'sd1686629713;
    localparam ang_t TWO_PI_Q30 = 36'sd6746518852;

    // Microdegrees to Q30 radians scale, split for two narrow partial products.
    localparam logic [34:0] UDEG_K = 35'd20122276272;
    localparam int K_SPLIT = 18;

    localparam logic [RADIUS_W-1:0] RADIUS_RESET = 24'd6371000;

    // Arctangent of 2^-i in Q30 radians.
    function automatic cw_t atan_const(input int i);
        cw_t r;
        begin
            case (i)
                0: r = 34'sd843314857;
                1: r = 34'sd497837830;
                2: r = 34'sd263043837;
                3: r = 34'sd133525159;
                4: r = 34'sd67021687;
                5: r = 34'sd33543516;
                6: r = 34'sd16775851;
                7: r = 34'sd8388437;
                8: r = 34'sd4194283;
                9: r = 34'sd2097149;
                10: r = 34'sd1048576;
                default: r = (i <= 30) ? (cw_t'(1) <<< (30 - i)) : '0;
            endcase
            return r;
        end
    endfunction

    // Q30 product with round half up and a floor shift.
    function automatic cw_t mul_q30(input cw_t a, input cw_t b);
        logic signed [2*CW-1:0] p;
        begin
            p = a * b;
            p = p + (68'sd1 <<< 29);
            return cw_t'(p >>> 30);
        end
    endfunction

endpackage

>>> design/hgcd_angle_prep.sv
// Converts microdegrees to Q30 radians, reduces into one turn and folds into the CORDIC range.
`timescale 1ns / 1ps

module hgcd_angle_prep
    import hgcd_pkg::*;
#(
    parameter int SH = 30
)
(
    input  logic  clk,
    input  logic  en,
    input  udeg_t d,
    output cw_t   z,
    output logic  neg
);

    logic        s1_sign_reg;
    logic [29:0] s1_mag_reg;
    logic        s2_sign_reg;
    logic [47:0] s2_pl_reg;
    logic [46:0] s2_ph_reg;
    ang_t        s3_ang_reg;
    ang_t        s4_ang_reg;
    ang_t        s5_ang_reg;
    cw_t         s6_z_reg;
    logic        s6_neg_reg;

    logic [65:0] s3_full;
    logic [34:0] s3_mag;
    ang_t        s3_ang_next;
    ang_t        s4_tmp;
    ang_t        s4_ang_next;
    ang_t        s5_tmp;
    ang_t        s5_ang_next;
    ang_t        s6_fold;
    logic        s6_neg_next;

    always_comb
    begin
        s3_full = {1'b0, s2_ph_reg, {K_SPLIT{1'b0}}} + 66'(s2_pl_reg) + (66'd1 << (SH - 1));
        s3_mag = s3_full[SH +: 35];
        s3_ang_next = s2_sign_reg ? -ang_t'(s3_mag) : ang_t'(s3_mag);

        s4_tmp = (s3_ang_reg > PI_Q30) ? s3_ang_reg - TWO_PI_Q30 : s3_ang_reg;
        s4_ang_next = (s4_tmp > PI_Q30) ? s4_tmp - TWO_PI_Q30 : s4_tmp;

        s5_tmp = (s4_ang_reg < -PI_Q30) ? s4_ang_reg + TWO_PI_Q30 : s4_ang_reg;
        s5_ang_next = (s5_tmp < -PI_Q30) ? s5_tmp + TWO_PI_Q30 : s5_tmp;

        if (s5_ang_reg > HALF_PI_Q30)
        begin
            s6_fold = PI_Q30 - s5_ang_reg;
            s6_neg_next = 1'b1;
        end
        else if (s5_ang_reg < -HALF_PI_Q30)
        begin
            s6_fold = -PI_Q30 - s5_ang_reg;
            s6_neg_next = 1'b1;
        end
        else
        begin
            s6_fold = s5_ang_reg;
            s6_neg_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_sign_reg <= d[DW-1];
            s1_mag_reg  <= d[DW-1] ? 30'(-d) : 30'(d);
            s2_sign_reg <= s1_sign_reg;
            s2_pl_reg   <= s1_mag_reg * UDEG_K[K_SPLIT-1:0];
            s2_ph_reg   <= s1_mag_reg * UDEG_K[34:K_SPLIT];
            s3_ang_reg  <= s3_ang_next;
            s4_ang_reg  <= s4_ang_next;
            s5_ang_reg  <= s5_ang_next;
            s6_z_reg    <= cw_t'(s6_fold);
            s6_neg_reg  <= s6_neg_next;
        end
    end

    assign z = s6_z_reg;
    assign neg = s6_neg_reg;

endmodule

>>> design/hgcd_cordic_cell.sv
// One CORDIC micro-rotation, rotation or vectoring mode, with registered outputs.
`timescale 1ns / 1ps

module hgcd_cordic_cell
    import hgcd_pkg::*;
#(
    parameter int STAGE = 0,
    parameter bit VECTOR = 1'b0
)
(
    input  logic clk,
    input  logic en,
    input  cw_t  x_in,
    input  cw_t  y_in,
    input  cw_t  z_in,
    output cw_t  x_out,
    output cw_t  y_out,
    output cw_t  z_out
);

    localparam cw_t ATAN_I = atan_const(STAGE);

    cw_t  x_reg;
    cw_t  y_reg;
    cw_t  z_reg;
    cw_t  dx;
    cw_t  dy;
    logic up;

    always_comb
    begin
        dx = y_in >>> STAGE;
        dy = x_in >>> STAGE;
        // Rotation steers z toward zero, vectoring steers y toward zero.
        up = VECTOR ? y_in[CW-1] : ~z_in[CW-1];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (VECTOR)
            begin
                x_reg <= up ? x_in - dx : x_in + dx;
                y_reg <= up ? y_in + dy : y_in - dy;
                z_reg <= up ? z_in - ATAN_I : z_in + ATAN_I;
            end
            else
            begin
                x_reg <= up ? x_in - dx : x_in + dx;
                y_reg <= up ? y_in + dy : y_in - dy;
                z_reg <= up ? z_in - ATAN_I : z_in + ATAN_I;
            end
        end
    end

    assign x_out = x_reg;
    assign y_out = y_reg;
    assign z_out = z_reg;

endmodule

>>> design/hgcd_sqrt_cell.sv
// One step of the bitwise integer square root, with registered outputs.
`timescale 1ns / 1ps

module hgcd_sqrt_cell
    import hgcd_pkg::*;
#(
    parameter int STEP = 0
)
(
    input  logic clk,
    input  logic en,
    input  sq_t  v_in,
    input  sq_t  r_in,
    output sq_t  v_out,
    output sq_t  r_out
);

    localparam sq_t BITV = sq_t'(1) << (2 * (SQRT_STEPS - 1) - 2 * STEP);

    sq_t  v_reg;
    sq_t  r_reg;
    sq_t  trial;
    logic fits;

    always_comb
    begin
        trial = r_in + BITV;
        fits = (v_in >= trial);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            v_reg <= fits ? v_in - trial : v_in;
            r_reg <= fits ? (r_in >> 1) + BITV : (r_in >> 1);
        end
    end

    assign v_out = v_reg;
    assign r_out = r_reg;

endmodule

>>> design/haversine_great_circle_distance.sv
// Top level: fully pipelined haversine great-circle distance, one point pair per beat.
// Throughput is one beat per cycle; the whole pipeline advances whenever the output register
// is empty or being taken, so a stalled output stalls every stage together.
// Reset clears all stage valid bits and loads the radius register with 6371000 m.
`timescale 1ns / 1ps

module haversine_great_circle_distance
    import hgcd_pkg::*;
#(
    parameter int CORDIC_STAGES = 28
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic signed [28:0]   start_lon,
    input  logic signed [27:0]   start_lat,
    input  logic signed [28:0]   end_lon,
    input  logic signed [27:0]   end_lat,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [DIST_W-1:0]    distance_mm,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [RADIUS_W-1:0]  cfg_data
);

    // Stage bookkeeping: six prep stages, rotation CORDIC, three haversine stages,
    // square root, vectoring CORDIC and three scaling stages (the last is the output).
    localparam int PREP = 6;
    localparam int LAT = 2 * CORDIC_STAGES + SQRT_STEPS + 12;
    localparam int V_HAV = PREP + CORDIC_STAGES + 2;
    localparam int V_SQRT = V_HAV + SQRT_STEPS;

    logic                 adv;
    logic [LAT-1:0]       vld_reg;
    logic [LAT-1:0]       vld_next;
    logic [RADIUS_W-1:0]  radius_reg;

    // Angle preparation lanes: half dlat, half dlon, lat1, lat2.
    udeg_t prep_d [4];
    cw_t   prep_z [4];
    logic  prep_neg [4];

    // Rotation CORDIC row per lane.
    cw_t rot_x [4][CORDIC_STAGES+1];
    cw_t rot_y [4][CORDIC_STAGES+1];
    cw_t rot_z [4][CORDIC_STAGES+1];

    // Fold sign of the two latitude lanes, carried alongside the rotation row.
    logic [1:0] neg_line_reg [CORDIC_STAGES];

    cw_t sin_dlat;
    cw_t sin_dlon;
    cw_t cos_lat1;
    cw_t cos_lat2;

    cw_t              sq_dlat_reg;
    cw_t              cos12_reg;
    cw_t              sq_dlon_reg;
    cw_t              sq_dlat2_reg;
    cw_t              prod_reg;
    logic [HAV_W-1:0] hav_reg;
    logic [HAV_W-1:0] hav_next;
    logic signed [CW:0] hav_sum;

    // Square root rows: lane 0 takes a, lane 1 takes 1 - a.
    sq_t sq_v [2][SQRT_STEPS+1];
    sq_t sq_r [2][SQRT_STEPS+1];

    cw_t vec_x [CORDIC_STAGES+1];
    cw_t vec_y [CORDIC_STAGES+1];
    cw_t vec_z [CORDIC_STAGES+1];

    logic [CW-1:0]         central;
    logic [57:0]           prod_rad_reg;
    logic [37:0]           hi_k_reg;
    logic [39:0]           lo_k_reg;
    logic [DIST_W-1:0]     dist_reg;
    logic [39:0]           lo_round;

    // A single enable moves every stage; the output register is the skid point.
    assign adv = ~vld_reg[LAT-1] | out_ready;
    assign in_ready = adv;
    assign out_valid = vld_reg[LAT-1];
    assign distance_mm = dist_reg;
    assign cfg_ready = 1'b1;

    always_comb
    begin
        vld_next = {vld_reg[LAT-2:0], in_valid};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
            radius_reg <= RADIUS_RESET;
        end
        else
        begin
            if (adv)
            begin
                vld_reg <= vld_next;
            end
            if (cfg_valid)
            begin
                radius_reg <= cfg_data;
            end
        end
    end

    // Differences are taken at full width before the radian conversion.
    assign prep_d[0] = udeg_t'(end_lat) - udeg_t'(start_lat);
    assign prep_d[1] = udeg_t'(end_lon) - udeg_t'(start_lon);
    assign prep_d[2] = udeg_t'(start_lat);
    assign prep_d[3] = udeg_t'(end_lat);

    genvar ln, st;
    generate
        for (ln = 0; ln < 4; ln++)
        begin : g_lane
            hgcd_angle_prep #(
                .SH (ln < 2 ? 31 : 30)
            ) u_prep (
                .clk (clk),
                .en  (adv),
                .d   (prep_d[ln]),
                .z   (prep_z[ln]),
                .neg (prep_neg[ln])
            );

            assign rot_x[ln][0] = GAIN_INV_Q30;
            assign rot_y[ln][0] = '0;
            assign rot_z[ln][0] = prep_z[ln];

            for (st = 0; st < CORDIC_STAGES; st++)
            begin : g_rot
                hgcd_cordic_cell #(
                    .STAGE  (st),
                    .VECTOR (1'b0)
                ) u_cell (
                    .clk   (clk),
                    .en    (adv),
                    .x_in  (rot_x[ln][st]),
                    .y_in  (rot_y[ln][st]),
                    .z_in  (rot_z[ln][st]),
                    .x_out (rot_x[ln][st+1]),
                    .y_out (rot_y[ln][st+1]),
                    .z_out (rot_z[ln][st+1])
                );
            end
        end
    endgenerate

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            neg_line_reg[0] <= {prep_neg[3], prep_neg[2]};
            for (int k = 1; k < CORDIC_STAGES; k++)
            begin
                neg_line_reg[k] <= neg_line_reg[k-1];
            end
        end
    end

    assign sin_dlat = rot_y[0][CORDIC_STAGES];
    assign sin_dlon = rot_y[1][CORDIC_STAGES];
    assign cos_lat1 = neg_line_reg[CORDIC_STAGES-1][0] ? -rot_x[2][CORDIC_STAGES]
                                                       : rot_x[2][CORDIC_STAGES];
    assign cos_lat2 = neg_line_reg[CORDIC_STAGES-1][1] ? -rot_x[3][CORDIC_STAGES]
                                                       : rot_x[3][CORDIC_STAGES];

    // Haversine term, saturated into [0, 1] in Q30.
    always_comb
    begin
        hav_sum = (CW+1)'(sq_dlat2_reg) + (CW+1)'(prod_reg);
        if (hav_sum < 0)
        begin
            hav_next = '0;
        end
        else if (hav_sum > (CW+1)'(ONE_Q30))
        begin
            hav_next = HAV_W'(ONE_Q30);
        end
        else
        begin
            hav_next = hav_sum[HAV_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sq_dlat_reg  <= mul_q30(sin_dlat, sin_dlat);
            cos12_reg    <= mul_q30(cos_lat1, cos_lat2);
            sq_dlon_reg  <= mul_q30(sin_dlon, sin_dlon);
            sq_dlat2_reg <= sq_dlat_reg;
            prod_reg     <= mul_q30(cos12_reg, sq_dlon_reg);
            hav_reg      <= hav_next;
        end
    end

    // Radicands are the Q30 values shifted up by 30 so the root lands in Q30.
    assign sq_v[0][0] = {{(SQW-HAV_W-30){1'b0}}, hav_reg, 30'b0};
    assign sq_v[1][0] = {{(SQW-HAV_W-30){1'b0}}, HAV_W'(ONE_Q30) - hav_reg, 30'b0};
    assign sq_r[0][0] = '0;
    assign sq_r[1][0] = '0;

    generate
        for (ln = 0; ln < 2; ln++)
        begin : g_sqrt
            for (st = 0; st < SQRT_STEPS; st++)
            begin : g_step
                hgcd_sqrt_cell #(
                    .STEP (st)
                ) u_cell (
                    .clk   (clk),
                    .en    (adv),
                    .v_in  (sq_v[ln][st]),
                    .r_in  (sq_r[ln][st]),
                    .v_out (sq_v[ln][st+1]),
                    .r_out (sq_r[ln][st+1])
                );
            end
        end
    endgenerate

    // Central half-angle: atan2(sqrt(a), sqrt(1 - a)) by vectoring.
    assign vec_x[0] = $signed({3'b0, sq_r[1][SQRT_STEPS][HAV_W-1:0]});
    assign vec_y[0] = $signed({3'b0, sq_r[0][SQRT_STEPS][HAV_W-1:0]});
    assign vec_z[0] = '0;

    generate
        for (st = 0; st < CORDIC_STAGES; st++)
        begin : g_vec
            hgcd_cordic_cell #(
                .STAGE  (st),
                .VECTOR (1'b1)
            ) u_cell (
                .clk   (clk),
                .en    (adv),
                .x_in  (vec_x[st]),
                .y_in  (vec_y[st]),
                .z_in  (vec_z[st]),
                .x_out (vec_x[st+1]),
                .y_out (vec_y[st+1]),
                .z_out (vec_z[st+1])
            );
        end
    endgenerate

    // A small negative angle left by the CORDIC is clamped to zero before doubling.
    assign central = vec_z[CORDIC_STAGES][CW-1] ? '0
                   : {vec_z[CORDIC_STAGES][CW-2:0], 1'b0};
    assign lo_round = lo_k_reg + 40'd536870912;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            prod_rad_reg <= radius_reg * central;
            hi_k_reg     <= prod_rad_reg[57:30] * 10'd1000;
            lo_k_reg     <= prod_rad_reg[29:0] * 10'd1000;
            dist_reg     <= DIST_W'(hi_k_reg + 38'(lo_round[39:30]));
        end
    end

    // A stalled output freezes every stage valid bit.
    a_stall_freezes: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |=> $stable(vld_reg))
        else $error("pipeline moved while the output was stalled");

    // An accepted beat enters the first stage.
    a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> vld_reg[0])
        else $error("accepted beat missing from the first stage");

    // A taken output with nothing behind it leaves the output empty.
    a_drain: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !vld_reg[LAT-2] |=> !out_valid)
        else $error("output beat repeated");

    // Square roots of values in [0, 1] never exceed one in Q30.
    a_sqrt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[V_SQRT] |-> (sq_r[0][SQRT_STEPS] <= SQW'(ONE_Q30))
                         && (sq_r[1][SQRT_STEPS] <= SQW'(ONE_Q30)))
        else $error("square root out of range");

endmodule

>>> tb/haversine_great_circle_distance_tb.sv
// Self-checking testbench for the haversine great-circle distance pipeline.
`timescale 1ns / 1ps

module haversine_great_circle_distance_tb
    import hgcd_pkg::*;
();

    localparam int STAGES = 28;
    // Input-to-output latency of the pipeline, used for the final drain.
    localparam int LATENCY_CYCLES = 2 * STAGES + 43;

    // Fixed-point constants of the distance arithmetic; the angles and the arctangent table are Q30 radians.
    localparam longint Q30_ONE = 64'sd1073741824;
    localparam longint Q30_PI = 64'sd3373259426;
    localparam longint Q30_HALF_PI = 64'sd1686629713;
    localparam longint Q30_GAIN_INV = 64'sd652032874;
    localparam bit [63:0] UDEG_TO_RAD_Q30 = 64'd20122276272;
    localparam longint ATAN_TABLE [0:10] = '{
        843314857, 497837830, 263043837, 133525159, 67021687, 33543516,
        16775851, 8388437, 4194283, 2097149, 1048576
    };

    // Coordinate limits in microdegrees, and the full widths of the ports.
    localparam longint LON_MAX = 180000000;
    localparam longint LAT_MAX = 90000000;
    localparam longint LON_WORD_MAX = (64'sd1 <<< 28) - 1;
    localparam longint LAT_WORD_MAX = (64'sd1 <<< 27) - 1;

    logic clk = 1'b0;
    logic rst_n;
    logic in_valid;
    logic in_ready;
    logic signed [28:0] start_lon;
    logic signed [27:0] start_lat;
    logic signed [28:0] end_lon;
    logic signed [27:0] end_lat;
    logic out_valid;
    logic out_ready;
    logic [DIST_W-1:0] distance_mm;
    logic cfg_valid;
    logic cfg_ready;
    logic [RADIUS_W-1:0] cfg_data;

    // The radius the predictor believes the block holds.
    logic [RADIUS_W-1:0] radius_m;
    // Distances still owed by the block, oldest first.
    logic [DIST_W-1:0] pending_distances [$];

    int send_idle_pct;
    int recv_idle_pct;
    int mismatches = 0;
    int pairs_sent;
    int distances_checked = 0;
    int radius_writes;

    haversine_great_circle_distance #(
        .CORDIC_STAGES(STAGES)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .start_lon(start_lon),
        .start_lat(start_lat),
        .end_lon(end_lon),
        .end_lat(end_lat),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .distance_mm(distance_mm),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data(cfg_data)
    );

    always #1 clk = ~clk;

    // ------------------------------------------------------------------
    // Distance predictor.
    // ------------------------------------------------------------------

    function automatic longint arctan_step(input int i);
        if (i <= 10)
            return ATAN_TABLE[i];
        if (i <= 30)
            return 64'sd1 <<< (30 - i);
        return 0;
    endfunction

    // Microdegrees to Q30 radians, rounding the magnitude half up. A shift of
    // 31 gives the half angle.
    function automatic longint udeg_to_rad(input longint d, input int sh);
        bit [63:0] mag;
        bit [63:0] r;
        mag = (d < 0) ? -d : d;
        r = (mag * UDEG_TO_RAD_Q30 + (64'd1 << (sh - 1))) >> sh;
        return (d < 0) ? -longint'(r) : longint'(r);
    endfunction

    function automatic longint q30_mul(input longint x, input longint y);
        return (x * y + (Q30_ONE >>> 1)) >>> 30;
    endfunction

    // Rotation CORDIC. The angle is first wrapped into [-pi, pi] and then
    // folded into [-pi/2, pi/2]; folding flips the sign of the cosine.
    function automatic void rotate_sin_cos(input longint angle,
                                           output longint sin_q, output longint cos_q);
        longint x;
        longint y;
        longint z;
        longint dx;
        longint dy;
        bit flip;
        x = Q30_GAIN_INV;
        y = 0;
        flip = 1'b0;
        repeat (2) if (angle > Q30_PI) angle -= 2 * Q30_PI;
        repeat (2) if (angle < -Q30_PI) angle += 2 * Q30_PI;
        if (angle > Q30_HALF_PI)
        begin
            angle = Q30_PI - angle;
            flip = 1'b1;
        end
        else if (angle < -Q30_HALF_PI)
        begin
            angle = -Q30_PI - angle;
            flip = 1'b1;
        end
        z = angle;
        for (int i = 0; i < STAGES; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0)
            begin
                x -= dx;
                y += dy;
                z -= arctan_step(i);
            end
            else
            begin
                x += dx;
                y -= dy;
                z += arctan_step(i);
            end
        end
        sin_q = y;
        cos_q = flip ? -x : x;
    endfunction

    // Exact bitwise square root of a Q30 value, giving Q30.
    function automatic longint root_q30(input longint a);
        bit [63:0] v;
        bit [63:0] res;
        bit [63:0] b;
        v = 64'(a) << 30;
        res = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0)
        begin
            if (v >= res + b)
            begin
                v -= res + b;
                res = (res >> 1) + b;
            end
            else
            begin
                res >>= 1;
            end
            b >>= 2;
        end
        return longint'(res);
    endfunction

    // Vectoring CORDIC; a slightly negative final angle is clamped to zero.
    function automatic longint vector_atan2(input longint y, input longint x);
        longint z;
        longint dx;
        longint dy;
        z = 0;
        for (int i = 0; i < STAGES; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (y >= 0)
            begin
                x += dx;
                y -= dy;
                z += arctan_step(i);
            end
            else
            begin
                x -= dx;
                y += dy;
                z -= arctan_step(i);
            end
        end
        return (z < 0) ? 0 : z;
    endfunction

    function automatic logic [DIST_W-1:0] great_circle_mm(
        input longint lon1, input longint lat1, input longint lon2, input longint lat2,
        input logic [RADIUS_W-1:0] radius);
        longint s_dlat;
        longint c_dlat;
        longint s_dlon;
        longint c_dlon;
        longint s_lat1;
        longint c_lat1;
        longint s_lat2;
        longint c_lat2;
        longint hav;
        longint central;
        bit [63:0] p;
        bit [63:0] whole;
        bit [63:0] frac;
        bit [63:0] mm;
        rotate_sin_cos(udeg_to_rad(lat2 - lat1, 31), s_dlat, c_dlat);
        rotate_sin_cos(udeg_to_rad(lon2 - lon1, 31), s_dlon, c_dlon);
        rotate_sin_cos(udeg_to_rad(lat1, 30), s_lat1, c_lat1);
        rotate_sin_cos(udeg_to_rad(lat2, 30), s_lat2, c_lat2);
        hav = q30_mul(s_dlat, s_dlat)
            + q30_mul(q30_mul(c_lat1, c_lat2), q30_mul(s_dlon, s_dlon));
        // The haversine term saturates to [0, 1].
        if (hav < 0) hav = 0;
        if (hav > Q30_ONE) hav = Q30_ONE;
        central = 2 * vector_atan2(root_q30(hav), root_q30(Q30_ONE - hav));
        p = 64'(radius) * 64'(central);
        whole = p >> 30;
        frac = p & 64'(Q30_ONE - 1);
        mm = whole * 1000 + ((frac * 1000 + 64'(Q30_ONE >>> 1)) >> 30);
        return mm[DIST_W-1:0];
    endfunction

    // ------------------------------------------------------------------
    // Checking and the output side.
    // ------------------------------------------------------------------

    task automatic report_mismatch(input string what);
        $display("ERROR at %0t: %s", $realtime, what);
        mismatches++;
    endtask

    // The receiver stalls at random; ready changes only at falling edges.
    always @(negedge clk)
    begin
        out_ready <= rst_n ? ($urandom_range(99) >= recv_idle_pct) : 1'b0;
    end

    // Each output beat is compared against the oldest owed distance.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_distances.size() == 0)
            begin
                report_mismatch($sformatf("distance_mm %0d with no pair outstanding",
                                          distance_mm));
            end
            else
            begin
                if (distance_mm !== pending_distances[0])
                    report_mismatch($sformatf("distance_mm got %0d, expected %0d",
                                              distance_mm, pending_distances[0]));
                void'(pending_distances.pop_front());
                distances_checked++;
            end
        end
    end

    // ------------------------------------------------------------------
    // Input side. Every task starts and ends just after a falling edge.
    // ------------------------------------------------------------------

    task automatic send_pair(input longint lon1, input longint lat1,
                             input longint lon2, input longint lat2);
        if ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
            while ($urandom_range(99) < send_idle_pct) @(negedge clk);
        end
        in_valid <= 1'b1;
        start_lon <= lon1[28:0];
        start_lat <= lat1[27:0];
        end_lon <= lon2[28:0];
        end_lat <= lat2[27:0];
        do @(posedge clk); while (!in_ready);
        // The prediction uses the values as the port holds them.
        pending_distances.push_back(great_circle_mm(
            longint'(start_lon), longint'(start_lat),
            longint'(end_lon), longint'(end_lat), radius_m));
        pairs_sent++;
        @(negedge clk);
    endtask

    // Holds the input idle until every owed distance has come back.
    task automatic wait_drained();
        in_valid <= 1'b0;
        while (pending_distances.size() != 0) @(negedge clk);
    endtask

    // The radius is only rewritten once the pipeline holds nothing.
    task automatic write_radius(input logic [RADIUS_W-1:0] value);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_data <= value;
        do @(posedge clk); while (!cfg_ready);
        radius_m = value;
        radius_writes++;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    function automatic longint rand_span(input longint lim);
        return longint'($urandom_range(2 * lim)) - lim;
    endfunction

    // ------------------------------------------------------------------
    // Tests.
    // ------------------------------------------------------------------

    // Extremes, poles, antipodes, identical points and out-of-range words.
    task automatic test_directed_geometry();
        send_pair(0, 0, 0, 0);
        send_pair(12345678, -4567890, 12345678, -4567890);
        send_pair(0, 0, LON_MAX, 0);
        send_pair(-LON_MAX, 0, LON_MAX, 0);
        send_pair(0, LAT_MAX, 0, -LAT_MAX);
        send_pair(0, -LAT_MAX, 0, LAT_MAX);
        send_pair(LON_MAX, LAT_MAX, -LON_MAX, LAT_MAX);
        send_pair(90000000, 45000000, -90000000, -45000000);
        send_pair(0, 0, 1, 0);
        send_pair(0, 0, 0, -1);
        send_pair(-1, -1, 1, 1);
        // Words beyond the coordinate range go through angle wrapping.
        send_pair(-LON_WORD_MAX - 1, -LAT_WORD_MAX - 1, LON_WORD_MAX, LAT_WORD_MAX);
        send_pair(LON_WORD_MAX, LAT_WORD_MAX, -LON_WORD_MAX - 1, -LAT_WORD_MAX - 1);
        send_pair(LON_WORD_MAX, 0, LON_WORD_MAX, LAT_WORD_MAX);
        send_pair(-LON_WORD_MAX - 1, LAT_WORD_MAX, 0, -LAT_WORD_MAX - 1);
        send_pair(179999999, 1, -179999999, -1);
    endtask

    // Mostly valid coordinates, with near pairs and a share of raw words.
    task automatic test_random_pairs(input int count, input int s_idle, input int r_idle);
        longint lon1;
        longint lat1;
        longint lon2;
        longint lat2;
        int kind;
        send_idle_pct = s_idle;
        recv_idle_pct = r_idle;
        for (int n = 0; n < count; n++)
        begin
            kind = $urandom_range(9);
            if (kind == 0)
            begin
                lon1 = rand_span(LON_WORD_MAX);
                lat1 = rand_span(LAT_WORD_MAX);
                lon2 = rand_span(LON_WORD_MAX);
                lat2 = rand_span(LAT_WORD_MAX);
            end
            else
            begin
                lon1 = rand_span(LON_MAX);
                lat1 = rand_span(LAT_MAX);
                if (kind <= 2)
                begin
                    // Short hops exercise the small-angle end of the CORDIC.
                    lon2 = lon1 + rand_span(20000);
                    lat2 = lat1 + rand_span(20000);
                end
                else
                begin
                    lon2 = rand_span(LON_MAX);
                    lat2 = rand_span(LAT_MAX);
                end
            end
            send_pair(lon1, lat1, lon2, lat2);
            if (n == count / 2)
                wait_drained();
        end
    endtask

    // Radius extremes, including zero, with both directed and random pairs.
    task automatic test_radius_settings();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_radius(24'hFFFFFF);
        test_directed_geometry();
        write_radius(24'd1);
        test_directed_geometry();
        write_radius(24'd0);
        test_random_pairs(20, 0, 0);
        write_radius(24'($urandom_range(1, 16777215)));
        test_random_pairs(40, 0, 0);
        write_radius(RADIUS_RESET);
    endtask

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        start_lon = '0;
        start_lat = '0;
        end_lon = '0;
        end_lat = '0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        radius_m = RADIUS_RESET;
        send_idle_pct = 12;
        recv_idle_pct = 78;
        pairs_sent = 0;
        radius_writes = 0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_directed_geometry();
        test_random_pairs(300, 12, 78);
        test_random_pairs(300, 78, 12);
        test_radius_settings();
        test_random_pairs(250, 0, 0);

        wait_drained();
        repeat (LATENCY_CYCLES + 20) @(negedge clk);
        $display("Covered %0d point pairs and %0d distances over %0d radius writes,",
                 pairs_sent, distances_checked, radius_writes);
        $display("with stalls on either side and radii from zero to full scale.");
        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    initial
    begin
        #1000000;
        $display("FAIL");
        $finish;
    end

endmodule

>>> haversine_great_circle_distance.f
design/hgcd_pkg.sv
design/hgcd_angle_prep.sv
design/hgcd_cordic_cell.sv
design/hgcd_sqrt_cell.sv
design/haversine_great_circle_distance.sv
tb/haversine_great_circle_distance_tb.sv
